[rtl/psw_pkg.sv]
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types and constants for the priority schedule wait-time block.
// ----------------------------------------------------------------------------
package psw_pkg;

  localparam int unsigned MaxProcsDef = 16;

  localparam int unsigned IdW    = 8;
  localparam int unsigned BurstW = 16;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned TickW  = 20;
  localparam int unsigned SumW   = 24;
  localparam int unsigned JobCntW = 5;
  localparam int unsigned JobCntMax = (1 << JobCntW) - 1;

  // One loaded job as it arrives on the command port.
  typedef struct packed {
    logic [IdW-1:0]    job_id;
    logic [BurstW-1:0] burst;
    logic [PrioW-1:0]  prio;
    logic              final_job;
  } job_in_t;

  // Stored job entry: prio in the top byte.
  typedef struct packed {
    logic [PrioW-1:0]  prio;
    logic [BurstW-1:0] burst;
    logic [IdW-1:0]    id;
  } job_entry_t;

  // One scheduled job with its timing.
  typedef struct packed {
    logic [IdW-1:0]     out_id;
    logic [BurstW-1:0]  out_burst;
    logic [PrioW-1:0]   out_prio;
    logic [TickW-1:0]   wait_ticks;
    logic [TickW-1:0]   turnaround_ticks;
    logic [SumW-1:0]    sum_wait;
    logic [SumW-1:0]    sum_turnaround;
    logic [JobCntW-1:0] job_count;
    logic               dropped_jobs;
    logic               end_of_run;
  } sched_out_t;

endpackage

[rtl/priority_schedule_wait_times.sv]
// ----------------------------------------------------------------------------
// priority_schedule_wait_times
// Non-preemptive priority scheduler: loads jobs, orders them by priority and
// reports waiting and turnaround time per job.
// ----------------------------------------------------------------------------
// Jobs are loaded one per cycle: an item is taken when start is high and busy
// is low, and busy stays low while a non-final job is loaded. The item with
// final_job set ends the load and raises busy. The n stored jobs are then
// ordered by selection sort in a job memory with separate read and write
// ports (one read, one write per cycle, registered read data): position i
// scans n-i entries, waits for the last read data and then writes the swap.
// One result comes out per position on res_o, marked by res_strobe_o for a
// single cycle; the receiver cannot hold results off.
// Jobs that arrive while the store is full are dropped and flagged on every
// result of that run.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times #(
  parameter int unsigned MaxProcs = psw_pkg::MaxProcsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  psw_pkg::job_in_t    job_i,
  output logic                res_strobe_o,
  output psw_pkg::sched_out_t res_o
);

  localparam int unsigned CntW = $clog2(MaxProcs + 1);
  localparam int unsigned IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StSwap = 3'b100
  } state_e;

  state_e st_q, st_d;

  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic            rd_vld_q;
  logic [CntW-1:0] rd_idx_q;

  psw_pkg::job_entry_t min_q, min_d;
  psw_pkg::job_entry_t head_q, head_d;
  logic [IdxW-1:0]     pos_q, pos_d;

  logic [psw_pkg::TickW-1:0] wait_q, wait_d;
  logic [psw_pkg::SumW-1:0]  sw_q, sw_d;
  logic [psw_pkg::SumW-1:0]  st_sum_q, st_sum_d;

  psw_pkg::sched_out_t res_q, res_d;
  logic                res_vld_q, res_vld_d;

  // job memory
  psw_pkg::job_entry_t mem [MaxProcs];
  psw_pkg::job_entry_t mem_rdata_q;
  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_waddr;
  psw_pkg::job_entry_t mem_wdata;

  logic                      accept;
  logic [CntW-1:0]           last_idx;
  logic [psw_pkg::TickW:0]   tat_sum;
  logic [psw_pkg::TickW-1:0] tat;
  logic [psw_pkg::SumW:0]    sw_sum, st_sum;
  logic [psw_pkg::SumW-1:0]  sw_sat, st_sat;
  logic [psw_pkg::JobCntW-1:0] cnt_sat;
  logic                      run_end;

  assign busy     = (st_q != StIdle);
  assign accept   = start && !busy;
  assign last_idx = count_q - CntW'(1);
  assign mem_re   = (st_q == StScan) && (j_q < count_q);

  // timing of the job taken at this swap
  assign tat_sum = {1'b0, wait_q} + (psw_pkg::TickW + 1)'(min_q.burst);
  assign tat     = tat_sum[psw_pkg::TickW] ? '1 : tat_sum[psw_pkg::TickW-1:0];
  assign sw_sum  = {1'b0, sw_q} + (psw_pkg::SumW + 1)'(wait_q);
  assign st_sum  = {1'b0, st_sum_q} + (psw_pkg::SumW + 1)'(tat);
  assign sw_sat  = sw_sum[psw_pkg::SumW] ? '1 : sw_sum[psw_pkg::SumW-1:0];
  assign st_sat  = st_sum[psw_pkg::SumW] ? '1 : st_sum[psw_pkg::SumW-1:0];
  assign cnt_sat = (int'(count_q) > int'(psw_pkg::JobCntMax)) ?
                   psw_pkg::JobCntW'(psw_pkg::JobCntMax) : psw_pkg::JobCntW'(count_q);
  assign run_end = (i_q == last_idx);

  always_comb begin
    st_d      = st_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    min_d     = min_q;
    head_d    = head_q;
    pos_d     = pos_q;
    wait_d    = wait_q;
    sw_d      = sw_q;
    st_sum_d  = st_sum_q;
    res_d     = res_q;
    res_vld_d = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = count_q[IdxW-1:0];
    mem_wdata = '{prio: job_i.prio, burst: job_i.burst, id: job_i.job_id};

    case (st_q)
      StIdle: begin
        if (accept) begin
          if (count_q < CntW'(MaxProcs)) begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (job_i.final_job) begin
            i_d  = '0;
            j_d  = '0;
            st_d = StScan;
          end
        end
      end
      StScan: begin
        if (mem_re) begin
          j_d = j_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (rd_idx_q == i_q) begin
            min_d  = mem_rdata_q;
            head_d = mem_rdata_q;
            pos_d  = i_q[IdxW-1:0];
          end else if (mem_rdata_q.prio < min_q.prio) begin
            // strict compare keeps the first lowest entry
            min_d = mem_rdata_q;
            pos_d = rd_idx_q[IdxW-1:0];
          end
          if (rd_idx_q == last_idx) begin
            st_d = StSwap;
          end
        end
      end
      StSwap: begin
        // displaced head goes where the minimum was; position i is done
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = head_q;
        res_vld_d = 1'b1;
        res_d.out_id           = min_q.id;
        res_d.out_burst        = min_q.burst;
        res_d.out_prio         = min_q.prio;
        res_d.wait_ticks       = wait_q;
        res_d.turnaround_ticks = tat;
        res_d.dropped_jobs     = ovf_q;
        res_d.end_of_run       = run_end;
        res_d.sum_wait         = run_end ? sw_sat : '0;
        res_d.sum_turnaround   = run_end ? st_sat : '0;
        res_d.job_count        = run_end ? cnt_sat : '0;
        if (run_end) begin
          count_d  = '0;
          ovf_d    = 1'b0;
          wait_d   = '0;
          sw_d     = '0;
          st_sum_d = '0;
          st_d     = StIdle;
        end else begin
          wait_d   = tat;
          sw_d     = sw_sat;
          st_sum_d = st_sat;
          i_d      = i_q + CntW'(1);
          j_d      = i_q + CntW'(1);
          st_d     = StScan;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[j_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      rd_vld_q  <= 1'b0;
      wait_q    <= '0;
      sw_q      <= '0;
      st_sum_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      i_q       <= i_d;
      j_q       <= j_d;
      rd_vld_q  <= mem_re;
      wait_q    <= wait_d;
      sw_q      <= sw_d;
      st_sum_q  <= st_sum_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= j_q;
    min_q    <= min_d;
    head_q   <= head_d;
    pos_q    <= pos_d;
    res_q    <= res_d;
  end

  assign res_strobe_o = res_vld_q;
  assign res_o        = res_q;

endmodule

[rtl/psw_checker.sv]
// ----------------------------------------------------------------------------
// psw_checker
// Port-level checks for the priority schedule wait-time block.
// ----------------------------------------------------------------------------
module psw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input psw_pkg::job_in_t    job_i,
  input logic                res_strobe_o,
  input psw_pkg::sched_out_t res_o
);

  // a non-final job never blocks the next one
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !job_i.final_job |=> !busy)
    else $error("busy after a non-final job");

  a_final_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && job_i.final_job |=> busy)
    else $error("final job did not start a run");

  // the last result frees the block, earlier ones come while it is busy
  a_end_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.end_of_run == !busy))
    else $error("end_of_run does not match busy");

  a_totals_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.end_of_run |->
      res_o.sum_wait == '0 && res_o.sum_turnaround == '0 && res_o.job_count == '0)
    else $error("totals on a result that is not the last");

  a_turnaround_ge_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> res_o.turnaround_ticks >= res_o.wait_ticks)
    else $error("turnaround below waiting time");

endmodule

bind priority_schedule_wait_times psw_checker u_psw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .job_i       (job_i),
  .res_strobe_o(res_strobe_o),
  .res_o       (res_o)
);
